FILE: src/complex_arith_polar_unit_top_assert.svh
`ifndef COMPLEX_ARITH_POLAR_UNIT_TOP_ASSERT_SVH
`define COMPLEX_ARITH_POLAR_UNIT_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define CAPU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define CAPU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/capu_pkg.sv
package capu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int GUARD = 24;
  localparam int MOD_STEPS = 14;

  typedef enum logic [2:0] {
    FN_ADD = 3'd0,
    FN_SUB = 3'd1,
    FN_MUL = 3'd2,
    FN_R2P = 3'd3,
    FN_P2R = 3'd4
  } func_t;

  typedef struct packed {
    func_t              func;
    logic               neg;
    logic               zero;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    logic signed [63:0] w;
  } rec_t;

  // shift-subtract quotient of nonnegative operands, elaboration only
  function automatic longint udiv(input longint num, input longint den);
    logic [63:0] nb;
    logic [64:0] rem;
    logic [63:0] quo;
    nb = num;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], nb[i]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return longint'(quo);
  endfunction

  // pi in Q60 by Machin's formula
  function automatic longint calc_pi_q60();
    longint n;
    longint nn;
    longint term;
    longint t;
    longint sum;
    longint acc;
    acc = 0;
    for (int m = 0; m < 2; m++) begin
      n = (m == 0) ? 64'sd5 : 64'sd239;
      term = udiv(64'sd1 <<< 60, n);
      nn = n * n;
      sum = 0;
      for (int k = 0; k < 64; k++) begin
        if (term != 0) begin
          t = udiv(term, longint'(2 * k + 1));
          sum = ((k & 1) == 1) ? sum - t : sum + t;
          term = udiv(term, nn);
        end
      end
      acc = (m == 0) ? acc + 4 * sum : acc - sum;
    end
    return 4 * acc;
  endfunction

  localparam longint PI_Q60 = calc_pi_q60();
  localparam longint HALF_PI_Q60 = PI_Q60 / 2;
  localparam longint TWOPI_Q46 = PI_Q60 >>> (29 - FRAC_BITS);
  localparam longint DEG_Q24 = (longint'(180) <<< 55) / (PI_Q60 >>> 29);

  function automatic longint atan_q60(input int i);
    longint sum;
    longint t;
    int e;
    sum = 0;
    if (i == 0) begin
      sum = PI_Q60 / 4;
    end else begin
      for (int k = 0; k < 31; k++) begin
        e = i * (2 * k + 1);
        if (e <= 60) begin
          t = udiv(64'sd1 <<< (60 - e), longint'(2 * k + 1));
          sum = ((k & 1) == 1) ? sum - t : sum + t;
        end
      end
    end
    return sum;
  endfunction

  // CORDIC gain 1/prod(sqrt(1+2^-2i)) in Q30
  function automatic longint gain_q30(input int steps);
    longint k2;
    longint r;
    longint b;
    k2 = 64'sd1 <<< 60;
    for (int i = 0; i < steps; i++) begin
      k2 = k2 - udiv(k2, (64'sd1 <<< (2 * i)) + 64'sd1);
    end
    r = 0;
    b = 64'sd1 <<< 62;
    for (int j = 0; j < 32; j++) begin
      if (b > k2) b = b >>> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (b != 0) begin
        if (k2 >= r + b) begin
          k2 = k2 - (r + b);
          r = (r >>> 1) + b;
        end else begin
          r = r >>> 1;
        end
        b = b >>> 2;
      end
    end
    return r;
  endfunction

endpackage

FILE: src/complex_arith_polar_unit_top.sv
// Complex arithmetic unit, Q16.16 operands and results.
// Input channel (in_valid/in_ready): func selects add, subtract, multiply,
// rect to polar (magnitude, angle in degrees) or polar to rect (radius,
// angle in radians). Output channel (out_valid/out_ready) carries res_first,
// res_second and saturated; every input transaction gives one result.
// Datapath is a row of registered cells: one input cell, 14 angle-reduction
// cells, two fold cells, CORDIC_STEPS rotation cells and two output cells.
// Every function goes down the same row, so results leave in input order.
// Throughput is one transaction per cycle while out_ready stays high; each
// cell holds its own valid bit, so empty cells fill even while the output
// register waits. When out_ready is low the result is held and cells
// upstream keep moving until they are full; in_ready then drops.
// Synchronous rst empties every cell; no results are pending afterward.
module complex_arith_polar_unit_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         func,
  input  logic signed [31:0] a_first,
  input  logic signed [31:0] a_second,
  input  logic signed [31:0] b_real,
  input  logic signed [31:0] b_imag,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] res_first,
  output logic signed [31:0] res_second,
  output logic               saturated
);

  localparam int MS = capu_pkg::MOD_STEPS;

  capu_pkg::rec_t mod_d [0:MS];
  logic           mod_v [0:MS];
  logic           mod_r [0:MS];
  capu_pkg::rec_t cor_d [0:CORDIC_STEPS];
  logic           cor_v [0:CORDIC_STEPS];
  logic           cor_r [0:CORDIC_STEPS];

  capu_pre #(.STEPS(CORDIC_STEPS)) u_pre (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .a_first(a_first), .a_second(a_second),
    .b_real(b_real), .b_imag(b_imag),
    .out_valid(mod_v[0]), .out_ready(mod_r[0]), .out_rec(mod_d[0])
  );

  for (genvar g = 0; g < MS; g++) begin : g_mod
    capu_mod_cell #(.SH(MS - 1 - g)) u_cell (
      .clk(clk), .rst(rst),
      .in_valid(mod_v[g]), .in_ready(mod_r[g]), .in_rec(mod_d[g]),
      .out_valid(mod_v[g+1]), .out_ready(mod_r[g+1]), .out_rec(mod_d[g+1])
    );
  end

  capu_fold u_fold (
    .clk(clk), .rst(rst),
    .in_valid(mod_v[MS]), .in_ready(mod_r[MS]), .in_rec(mod_d[MS]),
    .out_valid(cor_v[0]), .out_ready(cor_r[0]), .out_rec(cor_d[0])
  );

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    capu_cordic_cell #(.IDX(g)) u_cell (
      .clk(clk), .rst(rst),
      .in_valid(cor_v[g]), .in_ready(cor_r[g]), .in_rec(cor_d[g]),
      .out_valid(cor_v[g+1]), .out_ready(cor_r[g+1]), .out_rec(cor_d[g+1])
    );
  end

  capu_post #(.STEPS(CORDIC_STEPS)) u_post (
    .clk(clk), .rst(rst),
    .in_valid(cor_v[CORDIC_STEPS]), .in_ready(cor_r[CORDIC_STEPS]),
    .in_rec(cor_d[CORDIC_STEPS]),
    .out_valid(out_valid), .out_ready(out_ready),
    .res_first(res_first), .res_second(res_second), .saturated(saturated)
  );

endmodule

FILE: src/capu_pre.sv
module capu_pre #(
  parameter int STEPS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          func,
  input  logic signed [31:0]  a_first,
  input  logic signed [31:0]  a_second,
  input  logic signed [31:0]  b_real,
  input  logic signed [31:0]  b_imag,
  output logic                out_valid,
  input  logic                out_ready,
  output capu_pkg::rec_t      out_rec
);

  localparam logic signed [31:0] KQ30 = 32'(capu_pkg::gain_q30(STEPS));
  localparam logic signed [63:0] MOD_OFS =
    64'(capu_pkg::TWOPI_Q46 <<< (capu_pkg::MOD_STEPS - 1));

  capu_pkg::rec_t nxt;
  capu_pkg::rec_t q;
  logic vld;
  logic signed [63:0] a1;
  logic signed [63:0] a2;
  logic signed [63:0] b1;
  logic signed [63:0] b2;

  assign a1 = 64'(a_first);
  assign a2 = 64'(a_second);
  assign b1 = 64'(b_real);
  assign b2 = 64'(b_imag);

  always_comb begin
    nxt = '0;
    nxt.func = capu_pkg::func_t'(func);
    case (capu_pkg::func_t'(func))
      capu_pkg::FN_ADD: begin
        nxt.x = a1 + b1;
        nxt.y = a2 + b2;
      end
      capu_pkg::FN_SUB: begin
        nxt.x = a1 - b1;
        nxt.y = a2 - b2;
      end
      capu_pkg::FN_MUL: begin
        nxt.x = a_first * b_real;
        nxt.y = a_second * b_imag;
        nxt.z = a_first * b_imag;
        nxt.w = a_second * b_real;
      end
      capu_pkg::FN_R2P: begin
        nxt.neg = a_first[31];
        nxt.zero = (a_first == 32'sd0);
        nxt.x = (a_first[31] ? -a1 : a1) <<< capu_pkg::GUARD;
        nxt.y = a2 <<< capu_pkg::GUARD;
        nxt.w = a2;
      end
      capu_pkg::FN_P2R: begin
        nxt.x = a_first * KQ30;
        nxt.z = (a2 <<< 30) + MOD_OFS;
      end
      default: begin
        nxt.x = '0;
      end
    endcase
  end

  assign in_ready = !vld || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
    if (in_ready && in_valid) begin
      q <= nxt;
    end
  end

  assign out_valid = vld;
  assign out_rec = q;

endmodule

FILE: src/capu_mod_cell.sv
module capu_mod_cell #(
  parameter int SH = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  capu_pkg::rec_t in_rec,
  output logic           out_valid,
  input  logic           out_ready,
  output capu_pkg::rec_t out_rec
);

  localparam logic [63:0] STEP = 64'(capu_pkg::TWOPI_Q46 <<< SH);

  capu_pkg::rec_t nxt;
  capu_pkg::rec_t q;
  logic vld;

  always_comb begin
    nxt = in_rec;
    if (in_rec.func == capu_pkg::FN_P2R && $unsigned(in_rec.z) >= STEP) begin
      nxt.z = in_rec.z - $signed(STEP);
    end
  end

  assign in_ready = !vld || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
    if (in_ready && in_valid) begin
      q <= nxt;
    end
  end

  assign out_valid = vld;
  assign out_rec = q;

endmodule

FILE: src/capu_fold.sv
module capu_fold (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  capu_pkg::rec_t in_rec,
  output logic           out_valid,
  input  logic           out_ready,
  output capu_pkg::rec_t out_rec
);

  localparam logic signed [63:0] PI = 64'(capu_pkg::PI_Q60);
  localparam logic signed [63:0] HALF = 64'(capu_pkg::HALF_PI_Q60);

  capu_pkg::rec_t n1;
  capu_pkg::rec_t q1;
  capu_pkg::rec_t n2;
  capu_pkg::rec_t q2;
  logic vld1;
  logic vld2;
  logic rdy2;
  logic signed [64:0] mdiff;
  logic signed [64:0] msum;
  logic signed [63:0] zz;

  // mul: floor of exact product sums; p2r: gain shift and wrap into (-pi, pi]
  always_comb begin
    n1 = in_rec;
    mdiff = $signed({in_rec.x[63], in_rec.x}) - $signed({in_rec.y[63], in_rec.y});
    msum = $signed({in_rec.z[63], in_rec.z}) + $signed({in_rec.w[63], in_rec.w});
    zz = in_rec.z <<< (30 - capu_pkg::FRAC_BITS);
    case (in_rec.func)
      capu_pkg::FN_MUL: begin
        n1.x = 64'(mdiff >>> capu_pkg::FRAC_BITS);
        n1.y = 64'(msum >>> capu_pkg::FRAC_BITS);
      end
      capu_pkg::FN_P2R: begin
        n1.x = in_rec.x >>> (30 - capu_pkg::GUARD);
        n1.z = (zz > PI) ? zz - (PI <<< 1) : zz;
      end
      default: begin
        n1 = in_rec;
      end
    endcase
  end

  // fold into [-pi/2, pi/2], neg marks a half-turn
  always_comb begin
    n2 = q1;
    if (q1.func == capu_pkg::FN_P2R) begin
      n2.neg = 1'b0;
      if (q1.z > HALF) begin
        n2.z = q1.z - PI;
        n2.neg = 1'b1;
      end else if (q1.z < -HALF) begin
        n2.z = q1.z + PI;
        n2.neg = 1'b1;
      end
    end
  end

  assign rdy2 = !vld2 || out_ready;
  assign in_ready = !vld1 || rdy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
    end else begin
      if (in_ready) vld1 <= in_valid;
      if (rdy2) vld2 <= vld1;
    end
    if (in_ready && in_valid) q1 <= n1;
    if (rdy2 && vld1) q2 <= n2;
  end

  assign out_valid = vld2;
  assign out_rec = q2;

endmodule

FILE: src/capu_cordic_cell.sv
module capu_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  capu_pkg::rec_t in_rec,
  output logic           out_valid,
  input  logic           out_ready,
  output capu_pkg::rec_t out_rec
);

  localparam logic signed [63:0] ATAN = 64'(capu_pkg::atan_q60(IDX));

  capu_pkg::rec_t nxt;
  capu_pkg::rec_t q;
  logic vld;
  logic signed [63:0] xs;
  logic signed [63:0] ys;

  assign xs = in_rec.x >>> IDX;
  assign ys = in_rec.y >>> IDX;

  always_comb begin
    nxt = in_rec;
    case (in_rec.func)
      capu_pkg::FN_R2P: begin
        if (!in_rec.y[63]) begin
          nxt.x = in_rec.x + ys;
          nxt.y = in_rec.y - xs;
          nxt.z = in_rec.z + ATAN;
        end else begin
          nxt.x = in_rec.x - ys;
          nxt.y = in_rec.y + xs;
          nxt.z = in_rec.z - ATAN;
        end
      end
      capu_pkg::FN_P2R: begin
        if (!in_rec.z[63]) begin
          nxt.x = in_rec.x - ys;
          nxt.y = in_rec.y + xs;
          nxt.z = in_rec.z - ATAN;
        end else begin
          nxt.x = in_rec.x + ys;
          nxt.y = in_rec.y - xs;
          nxt.z = in_rec.z + ATAN;
        end
      end
      default: begin
        nxt = in_rec;
      end
    endcase
  end

  assign in_ready = !vld || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
    if (in_ready && in_valid) begin
      q <= nxt;
    end
  end

  assign out_valid = vld;
  assign out_rec = q;

endmodule

FILE: src/capu_post.sv
`include "complex_arith_polar_unit_top_assert.svh"

module capu_post #(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  capu_pkg::rec_t     in_rec,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] res_first,
  output logic signed [31:0] res_second,
  output logic               saturated
);

  localparam logic [29:0] KQ30 = 30'(capu_pkg::gain_q30(STEPS));
  localparam logic signed [31:0] DEGQ = 32'(capu_pkg::DEG_Q24);
  localparam logic signed [63:0] ANG90 = 64'sd90 <<< capu_pkg::FRAC_BITS;
  localparam logic signed [63:0] ANG180 = 64'sd180 <<< capu_pkg::FRAC_BITS;
  localparam logic signed [63:0] LIM_HI = 64'sd2147483647;
  localparam logic signed [63:0] LIM_LO = -64'sd2147483648;
  localparam logic signed [31:0] OUT_HI = 32'sh7fffffff;
  localparam logic signed [31:0] OUT_LO = 32'sh80000000;
  // CORDIC residue can push the angle slightly past +-90 degrees
  localparam logic signed [31:0] ANG_LO = -(32'sd91 <<< capu_pkg::FRAC_BITS);
  localparam logic signed [31:0] ANG_HI = 32'sd271 <<< capu_pkg::FRAC_BITS;

  capu_pkg::rec_t n1;
  capu_pkg::rec_t q1;
  capu_pkg::func_t func_q;
  logic vld1;
  logic rdy2;
  logic [26:0] xh;
  logic [29:0] xl;
  logic [56:0] mag_hi;
  logic [59:0] mag_lo;
  logic signed [31:0] zq;
  logic signed [63:0] ang_prod;
  logic signed [63:0] r1;
  logic signed [63:0] r2;
  logic signed [63:0] ang;
  logic sat1;
  logic sat2;
  logic clamped;
  logic r2p_out;
  logic ang_ok;
  logic unused_out;
  logic res_zero;

  assign xh = in_rec.x[56:30];
  assign xl = in_rec.x[29:0];
  assign mag_hi = xh * KQ30;
  assign mag_lo = xl * KQ30;
  assign zq = 32'(in_rec.z >>> 30);
  assign ang_prod = zq * DEGQ;

  always_comb begin
    n1 = in_rec;
    case (in_rec.func)
      capu_pkg::FN_R2P: begin
        if (in_rec.zero) begin
          n1.x = in_rec.w[63] ? -in_rec.w : in_rec.w;
          n1.y = (in_rec.w > 0) ? ANG90 : ((in_rec.w < 0) ? -ANG90 : 64'sd0);
        end else begin
          n1.x = 64'(mag_hi);
          n1.y = 64'(mag_lo >> 30);
          n1.z = ang_prod;
        end
      end
      capu_pkg::FN_P2R: begin
        n1.x = in_rec.neg ? -(in_rec.x >>> capu_pkg::GUARD) : in_rec.x >>> capu_pkg::GUARD;
        n1.y = in_rec.neg ? -(in_rec.y >>> capu_pkg::GUARD) : in_rec.y >>> capu_pkg::GUARD;
      end
      default: begin
        n1 = in_rec;
      end
    endcase
  end

  always_comb begin
    ang = q1.z >>> (54 - capu_pkg::FRAC_BITS);
    case (q1.func)
      capu_pkg::FN_ADD, capu_pkg::FN_SUB, capu_pkg::FN_MUL, capu_pkg::FN_P2R: begin
        r1 = q1.x;
        r2 = q1.y;
      end
      capu_pkg::FN_R2P: begin
        if (q1.zero) begin
          r1 = q1.x;
          r2 = q1.y;
        end else begin
          r1 = (q1.x + q1.y) >>> capu_pkg::GUARD;
          r2 = q1.neg ? ANG180 - ang : ang;
        end
      end
      default: begin
        r1 = '0;
        r2 = '0;
      end
    endcase
    sat1 = (r1 > LIM_HI) || (r1 < LIM_LO);
    sat2 = (r2 > LIM_HI) || (r2 < LIM_LO);
  end

  assign rdy2 = !out_valid || out_ready;
  assign in_ready = !vld1 || rdy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) vld1 <= in_valid;
      if (rdy2) out_valid <= vld1;
    end
    if (in_ready && in_valid) q1 <= n1;
    if (rdy2 && vld1) begin
      func_q <= q1.func;
      res_first <= (r1 > LIM_HI) ? OUT_HI : ((r1 < LIM_LO) ? OUT_LO : 32'(r1));
      res_second <= (r2 > LIM_HI) ? OUT_HI : ((r2 < LIM_LO) ? OUT_LO : 32'(r2));
      saturated <= sat1 || sat2;
    end
  end

  assign clamped = res_first == OUT_HI || res_first == OUT_LO ||
                   res_second == OUT_HI || res_second == OUT_LO;
  assign r2p_out = out_valid && func_q == capu_pkg::FN_R2P;
  assign ang_ok = res_second >= ANG_LO && res_second <= ANG_HI;
  assign unused_out = out_valid && !(func_q inside {capu_pkg::FN_ADD, capu_pkg::FN_SUB,
                      capu_pkg::FN_MUL, capu_pkg::FN_R2P, capu_pkg::FN_P2R});
  assign res_zero = res_first == 32'sd0 && res_second == 32'sd0 && !saturated;

  `CAPU_ASSERT_NOW(a_sat_bound, out_valid && saturated, clamped, "saturated without a clamped field")
  `CAPU_ASSERT_NOW(a_angle_range, r2p_out, ang_ok, "polar angle out of range")
  `CAPU_ASSERT_NOW(a_unused_zero, unused_out, res_zero, "unused function gave a nonzero result")
  `CAPU_ASSERT_NEXT(a_stage_move, vld1 && rdy2, out_valid, "finished transaction lost at the output stage")

endmodule
